// ----- rtl/mhd_pkg.sv -----
package mhd_pkg;

    localparam int MarkerLen = 13;
    localparam int HeaderLen = 25;
    localparam logic [30:0] MaxFrameSizeReset = 31'd10000000;

    typedef logic [4:0] hdr_pos_t;

    // One result item as it travels from the parser to the output register.
    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [30:0] frame_number;
        logic [30:0] source_id;
        logic [30:0] frame_size;
        logic        last;
    } mhd_result_t;

    localparam logic KindPayload = 1'b0;
    localparam logic KindEmpty   = 1'b1;

    // Byte expected at each position of the "[Data packet]" marker.
    function automatic logic [7:0] marker_byte(input logic [3:0] pos);
        logic [7:0] b;
        unique case (pos)
            4'd0:    b = 8'h5B; // [
            4'd1:    b = 8'h44; // D
            4'd2:    b = 8'h61; // a
            4'd3:    b = 8'h74; // t
            4'd4:    b = 8'h61; // a
            4'd5:    b = 8'h20; // space
            4'd6:    b = 8'h70; // p
            4'd7:    b = 8'h61; // a
            4'd8:    b = 8'h63; // c
            4'd9:    b = 8'h6B; // k
            4'd10:   b = 8'h65; // e
            4'd11:   b = 8'h74; // t
            4'd12:   b = 8'h5D; // ]
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/mhd_parser.sv -----
module mhd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic [30:0]         max_frame_size,
    output logic                res_valid,
    output mhd_pkg::mhd_result_t res
);
    import mhd_pkg::*;

    localparam hdr_pos_t MarkerPos = hdr_pos_t'(MarkerLen);
    localparam hdr_pos_t LastHdrPos = hdr_pos_t'(HeaderLen - 1);

    hdr_pos_t    pos_reg, pos_next;
    logic [31:0] frame_word_reg, frame_word_next;
    logic [31:0] length_word_reg, length_word_next;
    logic [31:0] source_word_reg, source_word_next;
    logic [30:0] payload_left_reg, payload_left_next;

    hdr_pos_t    idx;
    logic        hdr_ok;

    assign idx = pos_reg - MarkerPos;

    always_comb
    begin
        pos_next          = pos_reg;
        frame_word_next   = frame_word_reg;
        length_word_next  = length_word_reg;
        source_word_next  = source_word_reg;
        payload_left_next = payload_left_reg;
        res_valid         = 1'b0;
        hdr_ok            = 1'b0;

        if (accept && payload_left_reg == 31'd0 && pos_reg >= MarkerPos)
        begin
            unique case (idx[3:2])
                2'd0:    frame_word_next[{idx[1:0], 3'b000} +: 8] = in_byte;
                2'd1:    length_word_next[{idx[1:0], 3'b000} +: 8] = in_byte;
                default: source_word_next[{idx[1:0], 3'b000} +: 8] = in_byte;
            endcase
        end

        // The final header byte is checked together with the words it completes.
        hdr_ok = ((frame_word_next[31] | length_word_next[31] | source_word_next[31]) == 1'b0)
                 && (length_word_next[30:0] < max_frame_size);

        res.kind         = KindPayload;
        res.out_byte     = in_byte;
        res.frame_number = frame_word_next[30:0];
        res.source_id    = source_word_next[30:0];
        res.frame_size   = length_word_next[30:0];
        res.last         = 1'b0;

        if (accept)
        begin
            if (payload_left_reg != 31'd0)
            begin
                payload_left_next = payload_left_reg - 31'd1;
                res_valid         = 1'b1;
                res.last          = (payload_left_reg == 31'd1);
            end
            else if (pos_reg < MarkerPos)
            begin
                if (in_byte == marker_byte(pos_reg[3:0]))
                    pos_next = pos_reg + 5'd1;
                else if (in_byte == marker_byte(4'd0))
                    pos_next = 5'd1;
                else
                    pos_next = 5'd0;
            end
            else if (pos_reg == LastHdrPos)
            begin
                pos_next = 5'd0;
                if (hdr_ok)
                begin
                    if (length_word_next[30:0] == 31'd0)
                    begin
                        res_valid    = 1'b1;
                        res.kind     = KindEmpty;
                        res.out_byte = 8'd0;
                        res.last     = 1'b1;
                    end
                    else
                    begin
                        payload_left_next = length_word_next[30:0];
                    end
                end
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            frame_word_reg   <= '0;
            length_word_reg  <= '0;
            source_word_reg  <= '0;
            payload_left_reg <= '0;
        end
        else
        begin
            pos_reg          <= pos_next;
            frame_word_reg   <= frame_word_next;
            length_word_reg  <= length_word_next;
            source_word_reg  <= source_word_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

// ----- rtl/mhd_out_reg.sv -----
module mhd_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mhd_pkg::mhd_result_t load_data,
    input  logic                take,
    output logic                full,
    output mhd_pkg::mhd_result_t data
);
    import mhd_pkg::*;

    logic        full_reg, full_next;
    mhd_result_t data_reg;

    // A load only happens when the slot is empty or is being emptied this cycle.
    always_comb
    begin
        full_next = full_reg;
        if (load)
            full_next = 1'b1;
        else if (take)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign full = full_reg;
    assign data = data_reg;

endmodule

// ----- rtl/marker_header_deframer.sv -----
// Byte-stream deframer: hunts for the marker "[Data packet]", gathers the
// little-endian frame, size and source words, and passes size payload bytes
// through, each tagged with the header and the final one flagged last; a
// header of size zero yields one empty-frame item instead. Headers with any
// word's top bit set, or a size not below max_frame_size, are dropped and the
// hunt resumes at the next byte. The match and count state updates in the
// cycle the byte is accepted and any result lands in the output register, so
// a byte is accepted every cycle unless that register holds an item the
// consumer has not taken.
module marker_header_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [30:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  out_byte,
    output logic [30:0] frame_number,
    output logic [30:0] source_id,
    output logic [30:0] frame_size,
    output logic        last
);
    import mhd_pkg::*;

    logic [30:0] max_frame_size_reg;
    logic        accept;
    logic        res_valid;
    mhd_result_t res;
    mhd_result_t out_data;
    logic        out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_frame_size_reg <= MaxFrameSizeReset;
        else if (cfg_write_en)
            max_frame_size_reg <= cfg_write_data;
    end

    assign in_ready = !out_full || out_ready;
    assign accept   = in_valid && in_ready;

    mhd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .in_byte        (in_byte),
        .max_frame_size (max_frame_size_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    mhd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res),
        .take      (out_ready),
        .full      (out_full),
        .data      (out_data)
    );

    assign out_valid    = out_full;
    assign kind         = out_data.kind;
    assign out_byte     = out_data.out_byte;
    assign frame_number = out_data.frame_number;
    assign source_id    = out_data.source_id;
    assign frame_size   = out_data.frame_size;
    assign last         = out_data.last;

endmodule
